/* src/lge_pkg.sv */
// Shared types and constants of the life grid generation engine.
// Depends on nothing; imported by the engine's top level and its testbench.
`timescale 1ns / 1ps

package lge_pkg;

  // Field and register widths fixed by the interface.
  localparam int CMD_W      = 2;
  localparam int COORD_W    = 6;
  localparam int GRID_REG_W = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int NBR_W      = 4;

  // Reset value of both grid dimension registers.
  localparam logic [GRID_REG_W-1:0] GRID_DIM_RESET = 7'd64;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 2'd1;

  // Rule B3/S23: a dead cell is born with three neighbours, a live one
  // survives with two or three.
  localparam logic [NBR_W-1:0] BIRTH_COUNT   = 4'd3;
  localparam logic [NBR_W-1:0] SURVIVE_COUNT = 4'd2;

  typedef enum logic [CMD_W-1:0] {
    CMD_SET_ALIVE = 2'd0,
    CMD_QUERY     = 2'd1,
    CMD_STEP      = 2'd2,
    CMD_NOP       = 2'd3
  } cmd_t;

  typedef enum logic [8:0] {
    ST_CLEAR    = 9'b000000001,
    ST_IDLE     = 9'b000000010,
    ST_ACC_RD   = 9'b000000100,
    ST_ACC_CELL = 9'b000001000,
    ST_GEN_RD   = 9'b000010000,
    ST_GEN_SH   = 9'b000100000,
    ST_GEN_CELL = 9'b001000000,
    ST_GEN_WR   = 9'b010000000,
    ST_DONE     = 9'b100000000
  } state_t;

endpackage

/* src/life_grid_generation_engine.sv */
// Top level of the life grid generation engine: a double-buffered B3/S23 grid.
// Holds the row memory, the neighbour counting unit and its sequencer; uses lge_pkg.
`timescale 1ns / 1ps

//  Channel   Direction  Handshake             Payload
//  in_*      request    in_valid / in_stall   in_command, in_col, in_row
//  out_*     result     out_valid / out_stall out_alive, out_range_error
//  cfg_*     write      cfg_valid / cfg_ready cfg_index, cfg_data
//
//  A request is taken only in the idle state. A set or query reads its row and then its
//  cell, a no-op or a rejected coordinate goes straight to completion, and a generation
//  sweeps every row of the grid: the single neighbour counting unit visits one cell a cycle.
//  After reset a clearing pass zeroes the active plane row by row; in_stall stays high
//  meanwhile, while configuration writes are taken at any time.
//  A finished result waits in the output register while out_stall is high.

module life_grid_generation_engine #(
  parameter int MAX_COLS = 64,
  parameter int MAX_ROWS = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [lge_pkg::CMD_W-1:0]     in_command,
  input  logic [lge_pkg::COORD_W-1:0]   in_col,
  input  logic [lge_pkg::COORD_W-1:0]   in_row,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_alive,
  output logic                          out_range_error,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [lge_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lge_pkg::GRID_REG_W-1:0] cfg_data
);
  import lge_pkg::*;

  // Column index, row index and row fetch counter widths. The fetch counter
  // runs one row beyond the grid so that the bottom row sees an empty row below.
  localparam int CW = $clog2(MAX_COLS);
  localparam int RW = $clog2(MAX_ROWS);
  localparam int FW = $clog2(MAX_ROWS + 2);
  // Widths for comparing coordinates with the dimensions in use.
  localparam int UW = ($clog2(MAX_COLS + 1) > GRID_REG_W) ? $clog2(MAX_COLS + 1) : GRID_REG_W;
  localparam int UH = (FW > GRID_REG_W) ? FW : GRID_REG_W;

  state_t                state_r, state_nxt;
  logic [GRID_REG_W-1:0] grid_width_r, grid_height_r;
  logic [UW-1:0]         used_w;
  logic [UH-1:0]         used_h;
  logic                  plane_r, plane_nxt;
  cmd_t                  item_cmd_r, item_cmd_nxt;
  logic [COORD_W-1:0]    item_col_r, item_col_nxt;
  logic [COORD_W-1:0]    item_row_r, item_row_nxt;
  logic                  res_alive_r, res_alive_nxt;
  logic                  res_err_r, res_err_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_alive_r, out_alive_nxt;
  logic                  out_err_r, out_err_nxt;
  logic [MAX_COLS-1:0]   above_r, above_nxt;
  logic [MAX_COLS-1:0]   mid_r, mid_nxt;
  logic [MAX_COLS-1:0]   below_r, below_nxt;
  logic [MAX_COLS-1:0]   next_row_r, next_row_nxt;
  logic [CW-1:0]         col_r, col_nxt;
  logic [RW-1:0]         gen_row_r, gen_row_nxt;
  logic [FW-1:0]         fetch_row_r, fetch_row_nxt;
  logic                  prime_r, prime_nxt;

  // Row memory: one word per row of a plane, one bit per column.
  logic [MAX_COLS-1:0]   grid_mem [0:1][0:MAX_ROWS-1];
  logic [MAX_COLS-1:0]   rd_data_r;
  logic                  mem_we;
  logic                  mem_wr_plane;
  logic [RW-1:0]         mem_wr_row;
  logic [MAX_COLS-1:0]   mem_wr_data;
  logic [RW-1:0]         mem_rd_row;

  logic                  in_accept;
  logic                  out_free;
  logic                  in_range;
  logic [CW-1:0]         col_idx;
  logic [MAX_COLS-1:0]   set_row;
  logic                  cell_in_use;
  logic                  left_ok;
  logic                  right_ok;
  logic                  fetch_in_use;
  logic                  last_col;
  logic                  last_row;
  logic [7:0]            nbr_bits;
  logic [NBR_W-1:0]      nbr_count;
  logic                  next_cell;

  // Configuration registers are written whenever a request arrives.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r  <= GRID_DIM_RESET;
      grid_height_r <= GRID_DIM_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_GRID_WIDTH:  grid_width_r  <= cfg_data;
        CFG_GRID_HEIGHT: grid_height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // The dimensions in use are the register values clipped to the memory size.
  always_comb begin
    used_w = (UW'(grid_width_r) < UW'(MAX_COLS)) ? UW'(grid_width_r) : UW'(MAX_COLS);
    used_h = (UH'(grid_height_r) < UH'(MAX_ROWS)) ? UH'(grid_height_r) : UH'(MAX_ROWS);
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid       = out_valid_r;
  assign out_alive       = out_alive_r;
  assign out_range_error = out_err_r;

  assign in_range = (UW'(in_col) < used_w) && (UH'(in_row) < used_h);

  // Set and query touch a single bit of the row that was read.
  assign col_idx = CW'(item_col_r);
  always_comb begin
    set_row          = rd_data_r;
    set_row[col_idx] = 1'b1;
  end

  // Neighbour counting unit. The three window rows rotate right by one bit
  // per cell, so the cell under work always sits at bit 0, its right-hand
  // neighbours at bit 1 and its left-hand neighbours at the top bit.
  // Rows outside the grid in use were loaded as zero; columns are guarded here.
  assign cell_in_use  = (UW'(col_r) < used_w) && (UH'(gen_row_r) < used_h);
  assign left_ok      = (col_r != '0);
  assign right_ok     = ((UW'(col_r) + UW'(1)) < used_w);
  assign fetch_in_use = (UH'(fetch_row_r) < used_h);
  assign last_col     = (col_r == CW'(MAX_COLS - 1));
  assign last_row     = (gen_row_r == RW'(MAX_ROWS - 1));

  assign nbr_bits = {above_r[0], below_r[0],
                     left_ok & above_r[MAX_COLS-1], left_ok & mid_r[MAX_COLS-1],
                     left_ok & below_r[MAX_COLS-1],
                     right_ok & above_r[1], right_ok & mid_r[1], right_ok & below_r[1]};

  always_comb begin
    nbr_count = '0;
    for (int i = 0; i < 8; i++) begin
      nbr_count = nbr_count + NBR_W'(nbr_bits[i]);
    end
  end

  assign next_cell = cell_in_use &&
                     ((nbr_count == BIRTH_COUNT) ||
                      (mid_r[0] && (nbr_count == SURVIVE_COUNT)));

  // Memory port selection. The read port follows the fetch counter except
  // while a set or query reads its own row.
  assign mem_rd_row = (state_r == ST_ACC_RD) ? RW'(item_row_r) : fetch_row_r[RW-1:0];

  always_comb begin
    mem_we       = 1'b0;
    mem_wr_plane = plane_r;
    mem_wr_row   = gen_row_r;
    mem_wr_data  = '0;
    case (state_r)
      ST_CLEAR: begin
        mem_we       = 1'b1;
        mem_wr_plane = 1'b0;
      end
      ST_ACC_CELL: begin
        mem_we      = (item_cmd_r == CMD_SET_ALIVE);
        mem_wr_row  = RW'(item_row_r);
        mem_wr_data = set_row;
      end
      ST_GEN_WR: begin
        mem_we       = 1'b1;
        mem_wr_plane = ~plane_r;
        mem_wr_data  = next_row_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      grid_mem[mem_wr_plane][mem_wr_row] <= mem_wr_data;
    end
    rd_data_r <= grid_mem[plane_r][mem_rd_row];
  end

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    plane_nxt     = plane_r;
    item_cmd_nxt  = item_cmd_r;
    item_col_nxt  = item_col_r;
    item_row_nxt  = item_row_r;
    res_alive_nxt = res_alive_r;
    res_err_nxt   = res_err_r;
    out_valid_nxt = out_valid_r;
    out_alive_nxt = out_alive_r;
    out_err_nxt   = out_err_r;
    above_nxt     = above_r;
    mid_nxt       = mid_r;
    below_nxt     = below_r;
    next_row_nxt  = next_row_r;
    col_nxt       = col_r;
    gen_row_nxt   = gen_row_r;
    fetch_row_nxt = fetch_row_r;
    prime_nxt     = prime_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_CLEAR: begin
        gen_row_nxt = gen_row_r + RW'(1);
        if (last_row) begin
          gen_row_nxt = '0;
          state_nxt   = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_accept) begin
          item_cmd_nxt  = cmd_t'(in_command);
          item_col_nxt  = in_col;
          item_row_nxt  = in_row;
          res_alive_nxt = 1'b0;
          res_err_nxt   = 1'b0;
          if (cmd_t'(in_command) inside {CMD_SET_ALIVE, CMD_QUERY}) begin
            if (in_range) begin
              state_nxt = ST_ACC_RD;
            end else begin
              res_err_nxt = 1'b1;
              state_nxt   = ST_DONE;
            end
          end else if (cmd_t'(in_command) == CMD_STEP) begin
            above_nxt     = '0;
            mid_nxt       = '0;
            below_nxt     = '0;
            gen_row_nxt   = '0;
            fetch_row_nxt = '0;
            prime_nxt     = 1'b1;
            state_nxt     = ST_GEN_RD;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_ACC_RD: begin
        state_nxt = ST_ACC_CELL;
      end
      ST_ACC_CELL: begin
        if (item_cmd_r == CMD_QUERY) begin
          res_alive_nxt = rd_data_r[col_idx];
        end
        state_nxt = ST_DONE;
      end
      ST_GEN_RD: begin
        state_nxt = ST_GEN_SH;
      end
      ST_GEN_SH: begin
        above_nxt     = mid_r;
        mid_nxt       = below_r;
        below_nxt     = fetch_in_use ? rd_data_r : '0;
        fetch_row_nxt = fetch_row_r + FW'(1);
        if (prime_r) begin
          prime_nxt = 1'b0;
          state_nxt = ST_GEN_RD;
        end else begin
          col_nxt   = '0;
          state_nxt = ST_GEN_CELL;
        end
      end
      ST_GEN_CELL: begin
        above_nxt    = {above_r[0], above_r[MAX_COLS-1:1]};
        mid_nxt      = {mid_r[0], mid_r[MAX_COLS-1:1]};
        below_nxt    = {below_r[0], below_r[MAX_COLS-1:1]};
        next_row_nxt = {next_cell, next_row_r[MAX_COLS-1:1]};
        col_nxt      = col_r + CW'(1);
        if (last_col) begin
          state_nxt = ST_GEN_WR;
        end
      end
      ST_GEN_WR: begin
        // The finished row is written while the next row below is read.
        if (last_row) begin
          plane_nxt = ~plane_r;
          state_nxt = ST_DONE;
        end else begin
          gen_row_nxt = gen_row_r + RW'(1);
          state_nxt   = ST_GEN_SH;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_alive_nxt = res_alive_r;
          out_err_nxt   = res_err_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      plane_r     <= 1'b0;
      out_valid_r <= 1'b0;
      gen_row_r   <= '0;
      fetch_row_r <= '0;
      col_r       <= '0;
      prime_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      plane_r     <= plane_nxt;
      out_valid_r <= out_valid_nxt;
      gen_row_r   <= gen_row_nxt;
      fetch_row_r <= fetch_row_nxt;
      col_r       <= col_nxt;
      prime_r     <= prime_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_cmd_r  <= item_cmd_nxt;
    item_col_r  <= item_col_nxt;
    item_row_r  <= item_row_nxt;
    res_alive_r <= res_alive_nxt;
    res_err_r   <= res_err_nxt;
    out_alive_r <= out_alive_nxt;
    out_err_r   <= out_err_nxt;
    above_r     <= above_nxt;
    mid_r       <= mid_nxt;
    below_r     <= below_nxt;
    next_row_r  <= next_row_nxt;
  end

  // A cell can only be reported alive by a query that was in range.
  a_alive_not_error: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_alive_r) |-> !out_err_r)
    else $error("alive and range error reported together");

  // Writing the last row of a generation swaps the planes.
  a_plane_swap: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_GEN_WR && last_row) |=> (plane_r != $past(plane_r)))
    else $error("planes not swapped at end of generation");

  // Every row sweep starts at the first column.
  a_row_start: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_GEN_SH && !prime_r) |=> (state_r == ST_GEN_CELL && col_r == '0))
    else $error("row sweep did not start at column zero");

  // A result only appears from the completion state.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result raised outside completion");

  // An accepted generation request starts the row fetch.
  a_step_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_command == CMD_STEP) |=> (state_r == ST_GEN_RD))
    else $error("generation did not start");

endmodule

/* tb/sv/tb_life_grid_generation_engine.sv */
// Self-checking testbench for the life grid generation engine: a table of directed requests
// followed by random phases, each result checked against a typed value or a B3/S23 grid predictor.
// Depends on lge_pkg and life_grid_generation_engine.
`timescale 1ns / 1ps

module tb_life_grid_generation_engine;
  import lge_pkg::*;

  localparam int MAX_COLS = 64;
  localparam int MAX_ROWS = 64;
  localparam int CELLS    = MAX_COLS * MAX_ROWS;

  // A generation walks every cell once, with a row load and a row write around each row.
  localparam int GEN_CYCLES   = MAX_ROWS * (MAX_COLS + 2) + 5;
  // Cycles allowed after the last result before a register write or the verdict.
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES  = 64;
  // The receiver's long hold-off, long enough to back the engine up into its input.
  localparam int HOLD_CYCLES   = 300;
  localparam int RANDOM_ITEMS  = 108;
  // Well over the most generations a run can issue, plus every gap and stall, four times over.
  localparam int CYCLE_LIMIT   = 4 * (70 * GEN_CYCLES + 20000);
  localparam int REPORT_LIMIT  = 10;

  // A register index beyond the two the engine defines; writes to it must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_INDEX = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [CMD_W-1:0]      in_command;
  logic [COORD_W-1:0]    in_col;
  logic [COORD_W-1:0]    in_row;
  logic                  out_valid;
  logic                  out_stall;
  logic                  out_alive;
  logic                  out_range_error;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [GRID_REG_W-1:0] cfg_data;

  life_grid_generation_engine #(
    .MAX_COLS(MAX_COLS),
    .MAX_ROWS(MAX_ROWS)
  ) i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_command     (in_command),
    .in_col         (in_col),
    .in_row         (in_row),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_alive      (out_alive),
    .out_range_error(out_range_error),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  // One result as the engine should report it, with the request that caused it kept
  // alongside so that a mismatch can be traced.
  typedef struct {
    cmd_t               cmd;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic               alive;
    logic               range_error;
  } cell_report_t;

  // Rows of the directed table: either a request or a new grid size.
  typedef enum logic {ROW_REQUEST, ROW_GRID} row_kind_t;

  typedef struct {
    row_kind_t             kind;
    cmd_t                  cmd;
    logic [COORD_W-1:0]    col;
    logic [COORD_W-1:0]    row;
    bit                    typed;
    logic                  alive;
    logic                  range_error;
    logic [GRID_REG_W-1:0] grid_w;
    logic [GRID_REG_W-1:0] grid_h;
    bit                    poke_spare;
  } directed_row_t;

  // Predictor state: both planes, which one is active, and the two size registers.
  bit                    model_plane [0:1][0:CELLS-1];
  bit                    model_active;
  logic [GRID_REG_W-1:0] model_width;
  logic [GRID_REG_W-1:0] model_height;

  cell_report_t  cell_reports_due [$];
  directed_row_t directed_rows [$];

  int failure_count = 0;
  int requests_sent;
  int cycle_count;
  bit no_gaps;
  bit hold_request;

  // ---------------------------------------------------------------------------
  // Clock.
  // ---------------------------------------------------------------------------
  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor of the grid.
  // ---------------------------------------------------------------------------

  // The size in use never exceeds the stored planes, whatever the register holds.
  function automatic int used_cols();
    return (model_width < MAX_COLS) ? int'(model_width) : MAX_COLS;
  endfunction

  function automatic int used_rows();
    return (model_height < MAX_ROWS) ? int'(model_height) : MAX_ROWS;
  endfunction

  // Cells beyond the grid in use read as dead, so the edges do not wrap.
  function automatic int cell_live(int plane, int c, int r, int uw, int uh);
    if (c < 0 || r < 0 || c >= uw || r >= uh)
      return 0;
    return model_plane[plane][r * MAX_COLS + c] ? 1 : 0;
  endfunction

  // One generation into the inactive plane, every cell written, then the planes swap.
  function automatic void grid_advance();
    int  uw, uh, src, dst, n;
    bit  nv;
    uw  = used_cols();
    uh  = used_rows();
    src = model_active;
    dst = model_active ? 0 : 1;
    for (int r = 0; r < MAX_ROWS; r++) begin
      for (int c = 0; c < MAX_COLS; c++) begin
        nv = 1'b0;
        if (c < uw && r < uh) begin
          n = 0;
          for (int dr = -1; dr <= 1; dr++)
            for (int dc = -1; dc <= 1; dc++)
              if (dr != 0 || dc != 0)
                n += cell_live(src, c + dc, r + dr, uw, uh);
          if (cell_live(src, c, r, uw, uh) != 0)
            nv = (n == SURVIVE_COUNT || n == BIRTH_COUNT);
          else
            nv = (n == BIRTH_COUNT);
        end
        model_plane[dst][r * MAX_COLS + c] = nv;
      end
    end
    model_active = ~model_active;
  endfunction

  // Applies one request to the predictor and returns the report it should produce.
  function automatic cell_report_t grid_execute(cmd_t cmd, logic [COORD_W-1:0] col,
                                                logic [COORD_W-1:0] row);
    cell_report_t rep;
    rep.cmd         = cmd;
    rep.col         = col;
    rep.row         = row;
    rep.alive       = 1'b0;
    rep.range_error = 1'b0;
    case (cmd)
      CMD_SET_ALIVE, CMD_QUERY: begin
        if (col >= used_cols() || row >= used_rows()) begin
          rep.range_error = 1'b1;
        end else if (cmd == CMD_SET_ALIVE) begin
          model_plane[model_active][row * MAX_COLS + col] = 1'b1;
        end else begin
          rep.alive = model_plane[model_active][row * MAX_COLS + col];
        end
      end
      CMD_STEP: grid_advance();
      default: ;
    endcase
    return rep;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------

  // Most gaps are short, a few long; some phases run back to back with none at all.
  function automatic int pick_gap();
    int roll;
    if (no_gaps)
      return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55)
      return 0;
    if (roll < 90)
      return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Grid sizes lean towards small grids, where patterns interact, but the extremes
  // (empty, single cell, full, oversized) and any register value turn up too.
  function automatic logic [GRID_REG_W-1:0] pick_dim();
    case ($urandom_range(0, 9))
      0:       return 7'd0;
      1:       return 7'd1;
      2:       return 7'd64;
      3:       return 7'd127;
      4:       return GRID_REG_W'($urandom_range(0, 127));
      default: return GRID_REG_W'($urandom_range(3, 12));
    endcase
  endfunction

  function automatic void add_check(cmd_t cmd, int col, int row, logic alive, logic err);
    directed_row_t d;
    d             = '{kind: ROW_REQUEST, cmd: CMD_NOP, default: '0};
    d.kind        = ROW_REQUEST;
    d.cmd         = cmd;
    d.col         = COORD_W'(col);
    d.row         = COORD_W'(row);
    d.typed       = 1'b1;
    d.alive       = alive;
    d.range_error = err;
    directed_rows.push_back(d);
  endfunction

  function automatic void add_predicted(cmd_t cmd, int col, int row);
    directed_row_t d;
    d      = '{kind: ROW_REQUEST, cmd: CMD_NOP, default: '0};
    d.kind = ROW_REQUEST;
    d.cmd  = cmd;
    d.col  = COORD_W'(col);
    d.row  = COORD_W'(row);
    directed_rows.push_back(d);
  endfunction

  function automatic void add_grid(int w, int h, bit poke);
    directed_row_t d;
    d            = '{kind: ROW_GRID, cmd: CMD_NOP, default: '0};
    d.kind       = ROW_GRID;
    d.cmd        = CMD_NOP;
    d.grid_w     = GRID_REG_W'(w);
    d.grid_h     = GRID_REG_W'(h);
    d.poke_spare = poke;
    directed_rows.push_back(d);
  endfunction

  // Offers one request and holds it until the engine takes it. The expected report is
  // the typed one where the table gives it, else the predictor's; the predictor runs
  // either way so that its planes stay in step with the engine.
  task automatic send_request(input cmd_t cmd, input logic [COORD_W-1:0] col,
                              input logic [COORD_W-1:0] row, input bit typed,
                              input logic t_alive, input logic t_err);
    cell_report_t rep;
    int           gap;
    in_valid   <= 1'b1;
    in_command <= cmd;
    in_col     <= col;
    in_row     <= row;
    do @(posedge clk); while (in_stall);
    rep = grid_execute(cmd, col, row);
    if (typed) begin
      rep.alive       = t_alive;
      rep.range_error = t_err;
    end
    cell_reports_due.push_back(rep);
    requests_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // A set or query aimed at the window where the pattern lives; now and then a
  // coordinate anywhere, which is often outside the grid in use.
  task automatic send_cell(input cmd_t cmd, input int ox, input int oy,
                           input int wx, input int wy);
    logic [COORD_W-1:0] col, row;
    if (wx == 0 || wy == 0 || $urandom_range(0, 9) == 0) begin
      col = COORD_W'($urandom_range(0, 63));
      row = COORD_W'($urandom_range(0, 63));
    end else begin
      col = COORD_W'(ox + $urandom_range(0, wx - 1));
      row = COORD_W'(oy + $urandom_range(0, wy - 1));
    end
    send_request(cmd, col, row, 1'b0, 1'b0, 1'b0);
  endtask

  // The sender withdraws and waits until every report has come back. Each request
  // yields exactly one report, so an empty store means the engine has gone idle.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (cell_reports_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes both size registers back to back, and the spare index where asked.
  task automatic program_grid(input logic [GRID_REG_W-1:0] w,
                              input logic [GRID_REG_W-1:0] h, input bit poke);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_GRID_WIDTH;
    cfg_data  <= w;
    do @(posedge clk); while (!cfg_ready);
    model_width = w;
    cfg_index <= CFG_GRID_HEIGHT;
    cfg_data  <= h;
    do @(posedge clk); while (!cfg_ready);
    model_height = h;
    if (poke) begin
      cfg_index <= CFG_SPARE_INDEX;
      cfg_data  <= GRID_REG_W'($urandom_range(0, 127));
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: out_stall in stretches of random length. A hold request from the sender
  // starts a long hold-off, counted here, so that the engine backs up into in_stall.
  // ---------------------------------------------------------------------------
  initial begin : receiver
    int stall_left;
    int free_left;
    bit stall_now;
    bit hold_seen;
    out_stall  = 1'b0;
    stall_left = 0;
    free_left  = 0;
    hold_seen  = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request && !hold_seen) begin
        hold_seen  = 1'b1;
        free_left  = 0;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left == 0 && free_left == 0) begin
        free_left  = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                 : $urandom_range(0, 6);
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                 : $urandom_range(1, 3);
      end
      if (free_left > 0) begin
        free_left--;
        stall_now = 1'b0;
      end else begin
        stall_left--;
        stall_now = 1'b1;
      end
      out_stall <= stall_now;
    end
  end

  // ---------------------------------------------------------------------------
  // Checker: every report taken from the engine is matched against the oldest
  // expectation, field by field. Only the first few failures are printed.
  // ---------------------------------------------------------------------------
  task automatic report_failure(input string msg);
    failure_count++;
    if (failure_count <= REPORT_LIMIT)
      $display("ERROR: %s", msg);
  endtask

  always @(posedge clk) begin
    cell_report_t due;
    if (rst_n && out_valid && !out_stall) begin
      if (cell_reports_due.size() == 0) begin
        report_failure($sformatf("report with no request outstanding: alive %0b range_error %0b",
                                 out_alive, out_range_error));
      end else begin
        due = cell_reports_due.pop_front();
        if (out_alive !== due.alive || out_range_error !== due.range_error)
          report_failure($sformatf(
            "cmd %0d col %0d row %0d: expected alive %0b range_error %0b, got %0b %0b",
            due.cmd, due.col, due.row, due.alive, due.range_error,
            out_alive, out_range_error));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: a generous cycle limit, so that a hung handshake ends the run.
  // ---------------------------------------------------------------------------
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles", CYCLE_LIMIT);
    $display("life_grid_generation_engine verification failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Sender: reset, the directed table, then random phases, then the verdict.
  // ---------------------------------------------------------------------------
  initial begin : sender
    int phase;
    int random_start;
    int uw, uh, wx, wy, ox, oy;
    logic [GRID_REG_W-1:0] w, h;

    // Time-zero values of every input of the engine.
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_command = CMD_NOP;
    in_col     = '0;
    in_row     = '0;
    cfg_valid  = 1'b0;
    cfg_index  = CFG_GRID_WIDTH;
    cfg_data   = GRID_DIM_RESET;

    requests_sent = 0;
    no_gaps       = 1'b0;
    hold_request  = 1'b0;
    model_active  = 1'b0;
    model_width   = GRID_DIM_RESET;
    model_height  = GRID_DIM_RESET;
    for (int i = 0; i < CELLS; i++) begin
      model_plane[0][i] = 1'b0;
      model_plane[1][i] = 1'b0;
    end

    // After reset the whole grid is dead and the full 64 by 64 area is in use.
    add_check(CMD_QUERY, 0, 0, 1'b0, 1'b0);
    add_check(CMD_QUERY, 63, 63, 1'b0, 1'b0);
    add_check(CMD_SET_ALIVE, 63, 63, 1'b0, 1'b0);
    add_check(CMD_QUERY, 63, 63, 1'b1, 1'b0);
    add_check(CMD_NOP, 63, 63, 1'b0, 1'b0);
    // Shrinking the grid hides the far corner cell, which now reads as out of range.
    add_grid(8, 8, 1'b0);
    add_check(CMD_QUERY, 63, 63, 1'b0, 1'b1);
    add_check(CMD_SET_ALIVE, 8, 0, 1'b0, 1'b1);
    add_check(CMD_SET_ALIVE, 0, 8, 1'b0, 1'b1);
    // A blinker, which flips between a row and a column on each generation.
    add_check(CMD_SET_ALIVE, 1, 2, 1'b0, 1'b0);
    add_check(CMD_SET_ALIVE, 2, 2, 1'b0, 1'b0);
    add_check(CMD_SET_ALIVE, 3, 2, 1'b0, 1'b0);
    add_check(CMD_STEP, 63, 63, 1'b0, 1'b0);
    add_predicted(CMD_QUERY, 2, 1);
    add_predicted(CMD_QUERY, 1, 2);
    add_predicted(CMD_STEP, 0, 0);
    add_predicted(CMD_QUERY, 1, 2);
    // Back to the full grid: the hidden corner cell was cleared by the generations.
    add_grid(64, 64, 1'b0);
    add_predicted(CMD_QUERY, 63, 63);
    // An empty grid rejects every coordinate, and a write to the spare index is inert.
    add_grid(0, 0, 1'b1);
    add_check(CMD_SET_ALIVE, 0, 0, 1'b0, 1'b1);
    add_check(CMD_QUERY, 0, 0, 1'b0, 1'b1);
    add_check(CMD_STEP, 0, 0, 1'b0, 1'b0);
    // Oversized registers are clipped to the stored planes.
    add_grid(127, 127, 1'b0);
    add_check(CMD_SET_ALIVE, 63, 0, 1'b0, 1'b0);
    add_check(CMD_QUERY, 63, 0, 1'b1, 1'b0);
    // A single cell has no neighbours and dies at the next generation.
    add_grid(1, 1, 1'b0);
    add_predicted(CMD_QUERY, 0, 0);
    add_check(CMD_SET_ALIVE, 0, 0, 1'b0, 1'b0);
    add_predicted(CMD_STEP, 0, 0);
    add_predicted(CMD_QUERY, 0, 0);

    // Synchronous reset, held from time zero and never asserted again.
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_GRID) begin
        wait_idle();
        program_grid(directed_rows[i].grid_w, directed_rows[i].grid_h,
                     directed_rows[i].poke_spare);
      end else begin
        send_request(directed_rows[i].cmd, directed_rows[i].col, directed_rows[i].row,
                     directed_rows[i].typed, directed_rows[i].alive,
                     directed_rows[i].range_error);
      end
    end

    // Random phases. Each picks a grid size while the engine is idle, seeds a pattern in
    // a small window, lets it evolve for a generation or two with queries in between,
    // and closes with a few requests of any command and coordinate.
    random_start = requests_sent;
    phase        = 0;
    while (requests_sent - random_start < RANDOM_ITEMS) begin
      w = pick_dim();
      h = pick_dim();
      wait_idle();
      program_grid(w, h, 1'b0);
      uw = used_cols();
      uh = used_rows();
      wx = (uw < 6) ? uw : 6;
      wy = (uh < 6) ? uh : 6;
      ox = 0;
      oy = 0;
      if (uw > wx)
        ox = ($urandom_range(0, 2) == 0) ? uw - wx : $urandom_range(0, uw - wx);
      if (uh > wy)
        oy = ($urandom_range(0, 2) == 0) ? uh - wy : $urandom_range(0, uh - wy);

      no_gaps = ($urandom_range(0, 3) == 0);
      // In one phase the receiver holds off for a long stretch while requests keep
      // coming back to back, so that the engine fills up and stalls its input.
      if (phase == 2) begin
        hold_request = 1'b1;
        no_gaps      = 1'b1;
      end

      repeat ($urandom_range(3, 10)) send_cell(CMD_SET_ALIVE, ox, oy, wx, wy);
      // Now and then the sender pauses until every report has come back.
      if ($urandom_range(0, 2) == 0)
        wait_idle();
      repeat ($urandom_range(1, 2)) begin
        send_request(CMD_STEP, COORD_W'($urandom_range(0, 63)),
                     COORD_W'($urandom_range(0, 63)), 1'b0, 1'b0, 1'b0);
        repeat ($urandom_range(2, 5)) send_cell(CMD_QUERY, ox, oy, wx, wy);
      end
      repeat ($urandom_range(1, 3))
        send_request(cmd_t'($urandom_range(0, 3)), COORD_W'($urandom_range(0, 63)),
                     COORD_W'($urandom_range(0, 63)), 1'b0, 1'b0, 1'b0);
      phase++;
    end

    // Every request has been taken: wait for the last report, then a little longer in
    // case the engine produces anything it should not.
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failure_count == 0 && cell_reports_due.size() == 0) begin
      $display("life_grid_generation_engine verification clean");
    end else begin
      $display("life_grid_generation_engine verification failed");
    end
    $finish;
  end

endmodule

/* files.f */
src/lge_pkg.sv
src/life_grid_generation_engine.sv
tb/sv/tb_life_grid_generation_engine.sv
